/* src/smoa_pkg.sv */
// shared types and constants for the sliding median outlier alert block
package smoa_pkg;

    localparam int WINDOW_MAX_DEF  = 64;
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int CFG_W           = 7;
    localparam int ALERT_W         = 32;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_REMOVE,
        CELL_INSERT
    } cell_op_t;

    // control seen by one cell of the sorted row
    typedef struct packed {
        cell_op_t op;
        logic     in_win;
    } cell_ctl_t;

endpackage

/* src/smoa_cell.sv */
// one cell of the sorted window: holds a value, shifts left on remove, right on insert
module smoa_cell
    import smoa_pkg::*;
#(
    parameter int W = SAMPLE_BITS_DEF
) (
    input  logic         aclk,
    input  cell_ctl_t    ctl,
    input  logic [W-1:0] key,
    input  logic [W-1:0] left_val,
    input  logic         left_above,
    input  logic [W-1:0] right_val,
    output logic [W-1:0] val,
    output logic         above
);

    logic [W-1:0] val_reg;
    logic [W-1:0] val_next;

    // outside the filled part a cell counts as larger than any key
    assign above = !ctl.in_win || (val_reg > key);
    assign val   = val_reg;

    always_comb begin
        val_next = val_reg;
        case (ctl.op)
            CELL_REMOVE: begin
                if (!(val_reg < key)) begin
                    val_next = right_val;
                end
            end
            CELL_INSERT: begin
                if (above) begin
                    val_next = left_above ? left_val : key;
                end
            end
            default: val_next = val_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        val_reg <= val_next;
    end

endmodule

/* src/smoa_sorted_row.sv */
// row of sorted-window cells, each talking only to its two neighbors
module smoa_sorted_row
    import smoa_pkg::*;
#(
    parameter int WINDOW_MAX  = WINDOW_MAX_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int CNT_W       = $clog2(WINDOW_MAX + 1)
) (
    input  logic                   aclk,
    input  cell_op_t               op,
    input  logic [SAMPLE_BITS-1:0] key,
    input  logic [CNT_W-1:0]       cnt,
    output logic [SAMPLE_BITS-1:0] cell_val [WINDOW_MAX]
);

    logic [SAMPLE_BITS-1:0] val   [WINDOW_MAX];
    logic                   above [WINDOW_MAX];

    for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
        cell_ctl_t              ctl;
        logic [SAMPLE_BITS-1:0] lv;
        logic                   la;
        logic [SAMPLE_BITS-1:0] rv;

        assign ctl.op     = op;
        assign ctl.in_win = (CNT_W'(i) < cnt);

        if (i == 0) begin : g_first
            assign lv = key;
            assign la = 1'b0;
        end else begin : g_left
            assign lv = val[i-1];
            assign la = above[i-1];
        end

        if (i == WINDOW_MAX - 1) begin : g_last
            assign rv = val[i];
        end else begin : g_right
            assign rv = val[i+1];
        end

        smoa_cell #(
            .W (SAMPLE_BITS)
        ) u_cell (
            .aclk       (aclk),
            .ctl        (ctl),
            .key        (key),
            .left_val   (lv),
            .left_above (la),
            .right_val  (rv),
            .val        (val[i]),
            .above      (above[i])
        );

        assign cell_val[i] = val[i];
    end

endmodule

/* src/sliding_median_outlier_alert.sv */
// top level of the sliding-window median outlier alert block
//
// usage:
// - input stream s_axis_*: tdata carries one unsigned sample, tuser the start
//   flag that opens a new stream (clears window fill and alert count first)
// - result stream m_axis_*: one transfer per input transfer, in order
// - cfg_wr_en / cfg_wr_data write the window size; a write empties the window
//   and keeps the alert count; write only while no item is in flight
// - a sample goes through the remove pass (full window only), the insert pass,
//   the pending result register and then the output register
// - no new input transfer is taken until the sequencer is idle again; the
//   cell row needs one pass to drop the oldest sample and one pass to insert
//   the new one
// - the arrival ring is a memory read once per sample for the oldest value
// - reset (aresetn low, synchronous) sets window size 1, empty window, zero
//   count; no clearing pass is needed, the fill level guards the stores
// - a stalled receiver holds the result in the output register; one more
//   finished result waits internally, then s_axis_tready stays low
module sliding_median_outlier_alert
    import smoa_pkg::*;
#(
    parameter int WINDOW_MAX  = WINDOW_MAX_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    localparam int S_TDATA_W  = ((SAMPLE_BITS + 7) / 8) * 8,
    localparam int M_TDATA_W  = ((SAMPLE_BITS + 1 + ALERT_W + 7) / 8) * 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // configuration write: window size
    input  logic                 cfg_wr_en,
    input  logic [CFG_W-1:0]     cfg_wr_data,
    // input stream
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [S_TDATA_W-1:0] s_axis_tdata,   // sample, zero pad
    input  logic                 s_axis_tuser,   // start_req
    // result stream
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [M_TDATA_W-1:0] m_axis_tdata,   // median_x2, alert_count, zero pad
    output logic [1:0]           m_axis_tuser    // window_full, alert
);

    localparam int CNT_W = $clog2(WINDOW_MAX + 1);
    localparam int IDX_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int DM_W  = SAMPLE_BITS + 1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_REMOVE,
        ST_INSERT
    } state_t;

    // ring memory in arrival order
    logic [SAMPLE_BITS-1:0] ring_mem [WINDOW_MAX];

    state_t                 state_reg,   state_next;
    logic [CNT_W-1:0]       n_reg,       n_next;
    logic [IDX_W-1:0]       tap_lo_reg,  tap_lo_next;
    logic [IDX_W-1:0]       tap_hi_reg,  tap_hi_next;
    logic [IDX_W-1:0]       ptr_reg,     ptr_next;
    logic [CNT_W-1:0]       fill_reg,    fill_next;
    logic [CNT_W-1:0]       ins_cnt_reg, ins_cnt_next;
    logic [ALERT_W-1:0]     total_reg,   total_next;
    logic [SAMPLE_BITS-1:0] smp_reg,     smp_next;
    logic [SAMPLE_BITS-1:0] old_reg;
    logic                   full_reg,    full_next;
    logic                   alert_reg,   alert_next;
    logic [DM_W-1:0]        dm_reg,      dm_next;
    logic                   pend_reg,    pend_next;
    logic                   mv_reg,      mv_next;
    logic                   mfull_reg,   mfull_next;
    logic                   malert_reg,  malert_next;
    logic [DM_W-1:0]        mdm_reg,     mdm_next;
    logic [ALERT_W-1:0]     mcnt_reg,    mcnt_next;

    // sorted cell row
    cell_op_t               row_op;
    logic [SAMPLE_BITS-1:0] row_key;
    logic [CNT_W-1:0]       row_cnt;
    logic [SAMPLE_BITS-1:0] cell_val [WINDOW_MAX];

    logic                   s_xfer;
    logic                   out_free;
    logic                   load_out;
    logic [SAMPLE_BITS-1:0] s_sample;
    logic [CNT_W-1:0]       fill_eff;
    logic [IDX_W-1:0]       ptr_start;
    logic [IDX_W-1:0]       ptr_eff;
    logic [CNT_W:0]         ptr_inc;
    logic                   full_now;
    logic [DM_W-1:0]        dm_calc;
    int                     cfg_eff;
    int                     cfg_half;

    assign s_sample = s_axis_tdata[SAMPLE_BITS-1:0];
    assign out_free = !mv_reg || m_axis_tready;
    assign load_out = pend_reg && out_free;
    assign s_axis_tready = (state_reg == ST_IDLE) && (!pend_reg || out_free);
    assign s_xfer   = s_axis_tvalid && s_axis_tready;

    // effective window for the slot and fill bookkeeping of this sample
    assign fill_eff  = s_axis_tuser ? '0 : fill_reg;
    assign ptr_start = s_axis_tuser ? '0 : ptr_reg;
    assign ptr_eff   = (CNT_W'(ptr_start) >= n_reg) ? '0 : ptr_start;
    assign ptr_inc   = (CNT_W + 1)'(ptr_eff) + 1'b1;
    assign full_now  = (fill_eff >= n_reg);

    // twice the median: sum of the two middle cells, same cell when odd
    assign dm_calc = DM_W'(cell_val[tap_lo_reg]) + DM_W'(cell_val[tap_hi_reg]);

    // window size written: zero acts as one, large values clip to the row
    always_comb begin
        if (cfg_wr_data == '0) begin
            cfg_eff = 1;
        end else if (int'(cfg_wr_data) > WINDOW_MAX) begin
            cfg_eff = WINDOW_MAX;
        end else begin
            cfg_eff = int'(cfg_wr_data);
        end
        cfg_half = cfg_eff / 2;
    end

    always_comb begin
        state_next   = state_reg;
        n_next       = n_reg;
        tap_lo_next  = tap_lo_reg;
        tap_hi_next  = tap_hi_reg;
        ptr_next     = ptr_reg;
        fill_next    = fill_reg;
        ins_cnt_next = ins_cnt_reg;
        total_next   = total_reg;
        smp_next     = smp_reg;
        full_next    = full_reg;
        alert_next   = alert_reg;
        dm_next      = dm_reg;
        pend_next    = pend_reg;
        row_op       = CELL_HOLD;
        row_key      = smp_reg;
        row_cnt      = ins_cnt_reg;

        if (cfg_wr_en) begin
            n_next      = CNT_W'(cfg_eff);
            tap_hi_next = IDX_W'(cfg_half);
            tap_lo_next = (cfg_eff % 2 == 1) ? IDX_W'(cfg_half) : IDX_W'(cfg_half - 1);
            fill_next   = '0;
            ptr_next    = '0;
        end

        if (load_out) begin
            pend_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_xfer) begin
                    smp_next   = s_sample;
                    full_next  = full_now;
                    alert_next = 1'b0;
                    dm_next    = full_now ? dm_calc : '0;
                    ptr_next   = (ptr_inc >= (CNT_W + 1)'(n_reg)) ? '0 : IDX_W'(ptr_inc);
                    if (s_axis_tuser) begin
                        total_next = '0;
                    end
                    if (full_now) begin
                        fill_next    = fill_eff;
                        ins_cnt_next = n_reg - 1'b1;
                        state_next   = ST_REMOVE;
                    end else begin
                        fill_next    = fill_eff + 1'b1;
                        ins_cnt_next = fill_eff;
                        state_next   = ST_INSERT;
                    end
                end
            end
            ST_REMOVE: begin
                // drop the oldest sample while judging the new one
                row_op  = CELL_REMOVE;
                row_key = old_reg;
                row_cnt = n_reg;
                if (DM_W'(smp_reg) >= dm_reg) begin
                    alert_next = 1'b1;
                    if (total_reg != '1) begin
                        total_next = total_reg + 1'b1;
                    end
                end
                state_next = ST_INSERT;
            end
            ST_INSERT: begin
                row_op     = CELL_INSERT;
                row_key    = smp_reg;
                row_cnt    = ins_cnt_reg;
                pend_next  = 1'b1;
                state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // output register
    always_comb begin
        mv_next     = mv_reg;
        mfull_next  = mfull_reg;
        malert_next = malert_reg;
        mdm_next    = mdm_reg;
        mcnt_next   = mcnt_reg;
        if (load_out) begin
            mv_next     = 1'b1;
            mfull_next  = full_reg;
            malert_next = alert_reg;
            mdm_next    = dm_reg;
            mcnt_next   = total_reg;
        end else if (m_axis_tready) begin
            mv_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            n_reg      <= CNT_W'(1);
            tap_lo_reg <= '0;
            tap_hi_reg <= '0;
            ptr_reg    <= '0;
            fill_reg   <= '0;
            total_reg  <= '0;
            pend_reg   <= 1'b0;
            mv_reg     <= 1'b0;
        end else begin
            state_reg  <= state_next;
            n_reg      <= n_next;
            tap_lo_reg <= tap_lo_next;
            tap_hi_reg <= tap_hi_next;
            ptr_reg    <= ptr_next;
            fill_reg   <= fill_next;
            total_reg  <= total_next;
            pend_reg   <= pend_next;
            mv_reg     <= mv_next;
        end
        ins_cnt_reg <= ins_cnt_next;
        smp_reg     <= smp_next;
        full_reg    <= full_next;
        alert_reg   <= alert_next;
        dm_reg      <= dm_next;
        mfull_reg   <= mfull_next;
        malert_reg  <= malert_next;
        mdm_reg     <= mdm_next;
        mcnt_reg    <= mcnt_next;
    end

    // arrival ring: fetch the oldest sample and overwrite its slot in one transfer
    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            old_reg           <= ring_mem[ptr_eff];
            ring_mem[ptr_eff] <= s_sample;
        end
    end

    smoa_sorted_row #(
        .WINDOW_MAX  (WINDOW_MAX),
        .SAMPLE_BITS (SAMPLE_BITS),
        .CNT_W       (CNT_W)
    ) u_row (
        .aclk     (aclk),
        .op       (row_op),
        .key      (row_key),
        .cnt      (row_cnt),
        .cell_val (cell_val)
    );

    assign m_axis_tvalid = mv_reg;
    assign m_axis_tdata  = M_TDATA_W'({mcnt_reg, mdm_reg});
    assign m_axis_tuser  = {malert_reg, mfull_reg};

    // fill level never runs past the window size
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= n_reg)
        else $error("fill level above window size");

    // an alert is only raised against a full window
    a_alert_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && m_axis_tuser[1]) |-> m_axis_tuser[0])
        else $error("alert without a full window");

    // a finished result waits only while the sequencer is idle
    a_pend_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_reg |-> (state_reg == ST_IDLE))
        else $error("result pending while row is busy");

    // a full-window transfer always goes through the remove pass
    a_remove_next: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_xfer && full_now) |=> (state_reg == ST_REMOVE))
        else $error("remove pass skipped");

endmodule
